// File: src/rblb_pkg.sv
// shared types for the ring buffer latest-before lookup block
package rblb_pkg;

   // width of the ring length register
   localparam int unsigned RING_LEN_W = 5;
   // width of one timestamp or payload word
   localparam int unsigned WORD_W = 64;

   // one stored record, time in the low word
   typedef struct packed {
      logic [WORD_W-1:0]        payload;
      logic signed [WORD_W-1:0] time_ns;
   } rec_type;

   // operation codes carried in req_tuser
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// File: src/rblb_ram.sv
// generic simple dual-port ram with registered read
module rblb_ram
   import rblb_pkg::*;
#(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ring_buffer_latest_before_lookup_core.sv
// top level of the ring buffer latest-before lookup block
//
// usage
//  - req channel: one beat per operation; req_tuser selects add (0) or find (1)
//  - an add writes {payload, time} at the write pointer and gives no rsp beat;
//    the ring keeps the newest ring_length records
//  - a find walks the ring from newest to oldest, one ram read per cycle, and
//    returns the first record whose time is strictly below the query
//  - a find ends early on a hit, else after reading all fill records (fill is
//    at most DEPTH) through the one read port; an empty ring skips the scan;
//    no further req beat is taken until the find hands over its rsp beat
//  - rsp channel: rsp_tuser = found, rsp_tdata = {payload, time}, both zero
//    when nothing matches
//  - the rsp beat sits in an output register; further adds are taken while it
//    waits, a finished find holds in its done state until the register frees
//  - csr channel: writes ring_length (0 or above DEPTH means DEPTH) and empties
//    the ring; write only while idle, a waiting csr beat holds off req beats
//  - reset: synchronous, empties the ring, sets ring_length to 16, no ram
//    clearing pass is needed since only written entries are ever read
module ring_buffer_latest_before_lookup_core
   import rblb_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [191:0]          req_tdata,   // entry_time_ns, entry_payload, query_ns
   input  logic                  req_tuser,   // func
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,   // hit_time_ns, hit_payload
   output logic                  rsp_tuser,   // found
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RING_LEN_W-1:0] csr_data     // ring_length
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned LEN_W = $clog2(DEPTH + 1);

   // request fields
   logic signed [WORD_W-1:0] entry_time_ns;
   logic [WORD_W-1:0]        entry_payload;
   logic signed [WORD_W-1:0] query_ns;
   logic                     func;

   assign entry_time_ns = req_tdata[WORD_W-1:0];
   assign entry_payload = req_tdata[2*WORD_W-1:WORD_W];
   assign query_ns      = req_tdata[3*WORD_W-1:2*WORD_W];
   assign func          = req_tuser;

   // control state
   state_type             state_ff, state_in;
   logic [RING_LEN_W-1:0] ring_len_ff, ring_len_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [PTR_W-1:0]      loc_ff, loc_in;
   logic [LEN_W-1:0]      issue_left_ff, issue_left_in;
   logic [LEN_W-1:0]      check_left_ff, check_left_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   logic signed [WORD_W-1:0] query_ff, query_in;
   logic                     hit_found_ff, hit_found_in;
   rec_type                  hit_rec_ff, hit_rec_in;
   logic                     rsp_found_ff, rsp_found_in;
   rec_type                  rsp_rec_ff, rsp_rec_in;

   // ram ports
   logic             ram_wr_en;
   rec_type          ram_wr_data;
   logic             ram_rd_en;
   rec_type          ram_rd_data;
   logic [2*WORD_W-1:0] ram_rd_bits;

   // effective ring length and derived pointers
   logic [LEN_W-1:0] eff_len;
   logic [PTR_W-1:0] last_idx;
   logic [PTR_W-1:0] wp_next;
   logic [PTR_W-1:0] wp_prev;
   logic [PTR_W-1:0] loc_prev;

   logic req_beat;
   logic csr_beat;
   logic out_free;
   logic is_hit;

   always_comb begin
      if ((ring_len_ff == '0) || (32'(ring_len_ff) > DEPTH)) begin
         eff_len = LEN_W'(DEPTH);
      end else begin
         eff_len = LEN_W'(ring_len_ff);
      end
   end

   assign last_idx = PTR_W'(eff_len - LEN_W'(1));
   assign wp_next  = ((LEN_W'(wp_ff) + LEN_W'(1)) == eff_len) ? '0 : wp_ff + PTR_W'(1);
   assign wp_prev  = (wp_ff == '0) ? last_idx : wp_ff - PTR_W'(1);
   assign loc_prev = (loc_ff == '0) ? last_idx : loc_ff - PTR_W'(1);

   // a csr beat wins the idle cycle, the req beat waits behind it
   assign req_tready = (state_ff == ST_IDLE) & ~csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid & req_tready;
   assign csr_beat   = csr_valid & csr_ready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // record store
   assign ram_wr_en           = req_beat & (func == FUNC_ADD);
   assign ram_wr_data.time_ns = entry_time_ns;
   assign ram_wr_data.payload = entry_payload;
   assign ram_rd_en           = (state_ff == ST_SCAN) && (issue_left_ff != '0);
   assign ram_rd_data         = rec_type'(ram_rd_bits);

   rblb_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (DEPTH)
   ) u_rblb_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (loc_ff),
      .rd_data (ram_rd_bits)
   );

   // signed compare on the record that came out of the ram this cycle
   assign is_hit = (ram_rd_data.time_ns < query_ff);

   always_comb begin
      state_in      = state_ff;
      ring_len_in   = ring_len_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      loc_in        = loc_ff;
      issue_left_in = issue_left_ff;
      check_left_in = check_left_ff;
      rd_pend_in    = 1'b0;
      query_in      = query_ff;
      hit_found_in  = hit_found_ff;
      hit_rec_in    = hit_rec_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_beat) begin
               // new length empties the ring
               ring_len_in = csr_data;
               wp_in       = '0;
               fill_in     = '0;
            end else if (req_beat) begin
               if (func == FUNC_ADD) begin
                  wp_in = wp_next;
                  if (fill_ff < eff_len) begin
                     fill_in = fill_ff + LEN_W'(1);
                  end
               end else begin
                  query_in      = query_ns;
                  loc_in        = wp_prev;
                  issue_left_in = fill_ff;
                  check_left_in = fill_ff;
                  hit_found_in  = 1'b0;
                  hit_rec_in    = '0;
                  // empty ring answers not-found straight away
                  state_in      = (fill_ff == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // one read issued per cycle, each compared in the cycle after it is issued
            if (issue_left_ff != '0) begin
               loc_in        = loc_prev;
               issue_left_in = issue_left_ff - LEN_W'(1);
               rd_pend_in    = 1'b1;
            end
            if (rd_pend_ff) begin
               check_left_in = check_left_ff - LEN_W'(1);
               if (is_hit) begin
                  hit_found_in = 1'b1;
                  hit_rec_in   = ram_rd_data;
                  state_in     = ST_DONE;
               end else if (check_left_ff == LEN_W'(1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_found_ff;
               rsp_rec_in   = hit_rec_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ring_len_ff   <= RING_LEN_W'(16);
         wp_ff         <= '0;
         fill_ff       <= '0;
         loc_ff        <= '0;
         issue_left_ff <= '0;
         check_left_ff <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ring_len_ff   <= ring_len_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
         loc_ff        <= loc_in;
         issue_left_ff <= issue_left_in;
         check_left_ff <= check_left_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      hit_found_ff <= hit_found_in;
      hit_rec_ff   <= hit_rec_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rec_ff   <= rsp_rec_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_rec_ff.payload, rsp_rec_ff.time_ns};

endmodule
